// ----- design/clsq_pkg.sv -----
package clsq_pkg;

    // Default geometry limits
    localparam int MAX_CELLS_ACROSS_DEF = 256;
    localparam int MAX_IMAGE_SIDE_DEF   = 4096;
    localparam int SHADE_LEVELS_DEF     = 5;
    localparam int MAX_CELL_ROWS        = 256;
    localparam int ROW_W                = $clog2(MAX_CELL_ROWS + 2);

    // Accumulator and fixed-point widths
    localparam int SUM_W      = 40;
    localparam int LUM_W      = 18;
    localparam int MEAN_W     = 16;
    localparam int GAIN_W     = 12;
    localparam int SCALE_FRAC = 24;
    localparam int SHADE_W    = 3;
    localparam int CELL_IDX_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_CELL_COLUMNS  = 3'd2,
        REG_CELL_ROWS     = 3'd3,
        REG_EXPOSURE_GAIN = 3'd4
    } t_cfg_reg;

    // Register reset values
    localparam logic [12:0] RST_IMAGE_WIDTH   = 13'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT  = 13'd480;
    localparam logic [8:0]  RST_CELL_COLUMNS  = 9'd80;
    localparam logic [8:0]  RST_CELL_ROWS     = 9'd24;
    localparam logic [11:0] RST_EXPOSURE_GAIN = 12'd768;

    typedef logic [15:0] t_lum_rom [256];

    localparam longint unsigned Q30_ONE   = 64'd1 << 30;
    localparam longint unsigned ROM_SCALE = 64'd10000 * Q30_ONE;

    // r^5 in Q30, truncating after each product
    function automatic longint unsigned pow5_q30(longint unsigned r);
        longint unsigned p;
        p = r;
        for (int k = 0; k < 4; k++) begin
            p = (p * r) >> 30;
        end
        return p;
    endfunction

    // sRGB code to linear light, Q30
    function automatic longint unsigned linear_q30(longint unsigned v);
        longint unsigned t;
        longint unsigned s;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        if (v <= 64'd10) begin
            return (v * 64'd100 * Q30_ONE) / 64'd329460;
        end
        t  = ((v * 64'd1000 + 64'd14025) * Q30_ONE) / 64'd269025;
        s  = (t * t) >> 30;
        lo = 64'd0;
        hi = Q30_ONE;
        // fifth root of s by bisection
        for (int k = 0; k < 32; k++) begin
            if (lo < hi) begin
                mid = (lo + hi + 64'd1) >> 1;
                if (pow5_q30(mid) <= s) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return (s * lo) >> 30;
    endfunction

    // Weighted linear table for one channel, Q0.16
    function automatic t_lum_rom build_rom(longint unsigned weight);
        t_lum_rom        rom;
        longint unsigned lin;
        for (int v = 0; v < 256; v++) begin
            lin    = linear_q30(longint'(v));
            rom[v] = 16'((lin * weight * 64'd65536) / ROM_SCALE);
        end
        return rom;
    endfunction

    localparam t_lum_rom RED_ROM   = build_rom(64'd2126);
    localparam t_lum_rom GREEN_ROM = build_rom(64'd7152);
    localparam t_lum_rom BLUE_ROM  = build_rom(64'd722);

endpackage

// ----- design/cell_luminance_shade_quantizer.sv -----
// Cell luminance shade quantizer: RGB pixels in raster order are turned into linear
// luminance by three 256-entry tables and summed per character cell in a column-sum
// memory (read, add, write back). When a cell's last pixel arrives the sum is divided
// by the cell area, scaled by the Q4.8 exposure gain and quantized to a shade level.
// One pixel is taken at a time, the next only when the last is through: an ordinary
// pixel passes accept, memory read-add-write and position update; one that closes a
// column cell adds the division that finds the next cell edge, one that closes a cell
// adds the mean division plus scaling and output (held while the previous result still
// waits to be taken), and a line that crosses a cell row edge adds the division for the
// next row edge. All divisions share one bit-serial divider. After reset and after any
// geometry register write the block clears every entry of the memory and then computes
// the first column and row cell edges before taking pixels.
module cell_luminance_shade_quantizer #(
    parameter int MAX_CELLS_ACROSS = clsq_pkg::MAX_CELLS_ACROSS_DEF,
    parameter int MAX_IMAGE_SIDE   = clsq_pkg::MAX_IMAGE_SIDE_DEF,
    parameter int SHADE_LEVELS     = clsq_pkg::SHADE_LEVELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // pixel in
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [23:0]                      i_s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // cell result out
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [39:0]                      o_m_tdata,   // shade_level[2:0],
                                                          // mean_luminance[18:3],
                                                          // out_cell_column[26:19],
                                                          // out_cell_row[34:27], zero
    output logic                             o_m_tlast,   // last_cell
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [clsq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [clsq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import clsq_pkg::*;

    localparam int PW  = $clog2(MAX_IMAGE_SIDE + 1);
    localparam int CCW = $clog2(MAX_CELLS_ACROSS + 2);
    localparam int AW  = (MAX_CELLS_ACROSS > 1) ? $clog2(MAX_CELLS_ACROSS) : 1;
    localparam int VW  = 2 * PW;
    localparam int LV  = SHADE_LEVELS - 1;

    typedef enum logic [3:0] {
        S_CLR, S_INIT_COL, S_INIT_ROW, S_IDLE, S_ACC, S_DIV_MEAN,
        S_SCALE, S_EMIT, S_ADV, S_DIV_COL, S_DIV_ROW
    } t_state;

    t_state r_state;

    // configuration registers
    logic [12:0]        r_image_width;
    logic [12:0]        r_image_height;
    logic [8:0]         r_cell_columns;
    logic [8:0]         r_cell_rows;
    logic [GAIN_W-1:0]  r_exposure_gain;

    // position state
    logic [PW-1:0]      r_pc;
    logic [PW-1:0]      r_pr;
    logic [CCW-1:0]     r_ccol;
    logic [ROW_W-1:0]   r_crow;
    logic [PW-1:0]      r_col_edge;
    logic [PW-1:0]      r_row_edge;
    logic [PW-1:0]      r_col_start;
    logic [PW-1:0]      r_row_start;
    logic [PW-1:0]      r_first_col;
    logic [PW-1:0]      r_first_row;

    // datapath
    logic [AW-1:0]      r_clr;
    logic [LUM_W-1:0]   r_lum;
    logic [SUM_W-1:0]   r_rd;
    logic [MEAN_W-1:0]  r_mean;
    logic [SCALE_FRAC:0] r_scaled;

    // divider handshake
    logic               r_div_start;
    logic               n_div_start;
    logic [SUM_W-1:0]   r_div_a;
    logic [VW-1:0]      r_div_b;
    logic               w_div_done;
    logic [SUM_W-1:0]   w_div_q;

    // result register
    logic               r_o_valid;
    logic [39:0]        r_o_data;
    logic               r_o_last;

    // column-sum memory
    logic [SUM_W-1:0]   r_mem [MAX_CELLS_ACROSS];
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [SUM_W-1:0]   w_wdata;
    logic [AW-1:0]      w_cc;

    // effective geometry
    logic [PW-1:0]      w_ew;
    logic [PW-1:0]      w_eh;
    logic [CCW-1:0]     w_ec;
    logic [ROW_W-1:0]   w_er;

    logic               w_col_hit;
    logic               w_row_hit;
    logic               w_emit;
    logic               w_wrap;
    logic [PW-1:0]      w_pc1;
    logic [PW-1:0]      w_pr1;
    logic [SUM_W-1:0]   n_sum;
    logic [VW-1:0]      n_area;
    logic [27:0]        n_gain_prod;
    logic [SCALE_FRAC+4:0] n_shade_prod;
    logic               w_cfg_acc;
    logic               w_in_acc;
    logic               w_out_free;

    // Clamp geometry so each cell holds at least one pixel
    always_comb begin
        int iw;
        int ih;
        int ic;
        int ir;
        int cmax;
        int rmax;
        iw = int'(r_image_width);
        ih = int'(r_image_height);
        iw = (iw < 1) ? 1 : ((iw > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : iw);
        ih = (ih < 1) ? 1 : ((ih > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : ih);
        cmax = (iw < MAX_CELLS_ACROSS) ? iw : MAX_CELLS_ACROSS;
        rmax = (ih < MAX_CELL_ROWS) ? ih : MAX_CELL_ROWS;
        ic = int'(r_cell_columns);
        ir = int'(r_cell_rows);
        ic = (ic < 1) ? 1 : ((ic > cmax) ? cmax : ic);
        ir = (ir < 1) ? 1 : ((ir > rmax) ? rmax : ir);
        w_ew = PW'(iw);
        w_eh = PW'(ih);
        w_ec = CCW'(ic);
        w_er = ROW_W'(ir);
    end

    // Position compares and accumulate
    always_comb begin
        w_pc1     = r_pc + PW'(1);
        w_pr1     = r_pr + PW'(1);
        w_col_hit = w_pc1 == r_col_edge;
        w_row_hit = w_pr1 == r_row_edge;
        w_emit    = w_col_hit && w_row_hit;
        w_wrap    = {1'b0, w_pc1} >= {1'b0, w_ew};
        w_cc      = (int'(r_ccol) < MAX_CELLS_ACROSS) ? AW'(r_ccol) : AW'(MAX_CELLS_ACROSS - 1);
        n_sum     = r_rd + SUM_W'(r_lum);
        n_area    = VW'(r_col_edge - r_col_start) * VW'(r_row_edge - r_row_start);
        if (n_area == '0) begin
            n_area = VW'(1);
        end
        n_gain_prod  = 28'(r_mean) * 28'(r_exposure_gain);
        n_shade_prod = (SCALE_FRAC+5)'(r_scaled) * (SCALE_FRAC+5)'(LV);
    end

    // Launch a division in the cycle after the step that needs it
    always_comb begin
        case (r_state)
            S_CLR:      n_div_start = int'(r_clr) == MAX_CELLS_ACROSS - 1;
            S_INIT_COL: n_div_start = w_div_done;
            S_ACC:      n_div_start = w_emit;
            S_ADV:      n_div_start = w_wrap
                                    ? (({1'b0, w_pr1} < {1'b0, w_eh}) && w_row_hit)
                                    : w_col_hit;
            default:    n_div_start = 1'b0;
        endcase
    end

    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_o_valid || i_m_tready;

    assign o_cfg_ready = r_state == S_IDLE;
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;

    // Memory write port: clearing sweep or read-modify-write
    always_comb begin
        w_we    = (r_state == S_CLR) || (r_state == S_ACC);
        w_waddr = (r_state == S_CLR) ? r_clr : w_cc;
        w_wdata = ((r_state == S_CLR) || w_emit) ? '0 : n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_cc];
    end

    clsq_div #(
        .DW (SUM_W),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // Sequencer, position state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLR;
            r_clr           <= '0;
            r_div_start     <= 1'b0;
            r_o_valid       <= 1'b0;
            r_image_width   <= RST_IMAGE_WIDTH;
            r_image_height  <= RST_IMAGE_HEIGHT;
            r_cell_columns  <= RST_CELL_COLUMNS;
            r_cell_rows     <= RST_CELL_ROWS;
            r_exposure_gain <= RST_EXPOSURE_GAIN;
            r_pc            <= '0;
            r_pr            <= '0;
            r_ccol          <= '0;
            r_crow          <= '0;
            r_col_edge      <= '0;
            r_row_edge      <= '0;
            r_col_start     <= '0;
            r_row_start     <= '0;
            r_first_col     <= '0;
            r_first_row     <= '0;
        end else begin
            r_div_start <= n_div_start;
            // drop a taken result
            if (r_o_valid && i_m_tready && (r_state != S_EMIT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_pc        <= '0;
                    r_pr        <= '0;
                    r_ccol      <= '0;
                    r_crow      <= '0;
                    r_col_start <= '0;
                    r_row_start <= '0;
                    r_clr       <= r_clr + AW'(1);
                    if (int'(r_clr) == MAX_CELLS_ACROSS - 1) begin
                        r_div_a     <= SUM_W'(w_ew);
                        r_div_b     <= VW'(w_ec);
                        r_state     <= S_INIT_COL;
                    end
                end
                S_INIT_COL: begin
                    if (w_div_done) begin
                        r_first_col <= PW'(w_div_q);
                        r_col_edge  <= PW'(w_div_q);
                        r_div_a     <= SUM_W'(w_eh);
                        r_div_b     <= VW'(w_er);
                        r_state     <= S_INIT_ROW;
                    end
                end
                S_INIT_ROW: begin
                    if (w_div_done) begin
                        r_first_row <= PW'(w_div_q);
                        r_row_edge  <= PW'(w_div_q);
                        r_state     <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_cfg_acc) begin
                        case (i_cfg_index)
                            REG_IMAGE_WIDTH: begin
                                r_image_width <= i_cfg_data;
                                r_clr         <= '0;
                                r_state       <= S_CLR;
                            end
                            REG_IMAGE_HEIGHT: begin
                                r_image_height <= i_cfg_data;
                                r_clr          <= '0;
                                r_state        <= S_CLR;
                            end
                            REG_CELL_COLUMNS: begin
                                r_cell_columns <= i_cfg_data[8:0];
                                r_clr          <= '0;
                                r_state        <= S_CLR;
                            end
                            REG_CELL_ROWS: begin
                                r_cell_rows <= i_cfg_data[8:0];
                                r_clr       <= '0;
                                r_state     <= S_CLR;
                            end
                            REG_EXPOSURE_GAIN: begin
                                r_exposure_gain <= i_cfg_data[GAIN_W-1:0];
                            end
                            default: begin
                            end
                        endcase
                    end else if (w_in_acc) begin
                        r_lum <= LUM_W'(RED_ROM[i_s_tdata[7:0]])
                               + LUM_W'(GREEN_ROM[i_s_tdata[15:8]])
                               + LUM_W'(BLUE_ROM[i_s_tdata[23:16]]);
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (w_emit) begin
                        r_div_a     <= n_sum;
                        r_div_b     <= n_area;
                        r_state     <= S_DIV_MEAN;
                    end else begin
                        r_state <= S_ADV;
                    end
                end
                S_DIV_MEAN: begin
                    if (w_div_done) begin
                        r_mean  <= (|w_div_q[SUM_W-1:MEAN_W]) ? '1 : w_div_q[MEAN_W-1:0];
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_scaled <= (n_gain_prod > 28'(1 << SCALE_FRAC))
                              ? (SCALE_FRAC+1)'(1 << SCALE_FRAC)
                              : n_gain_prod[SCALE_FRAC:0];
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the result register is free
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_data  <= {5'd0,
                                      r_crow[CELL_IDX_W-1:0],
                                      CELL_IDX_W'(w_cc),
                                      r_mean,
                                      n_shade_prod[SCALE_FRAC+SHADE_W-1:SCALE_FRAC]};
                        r_o_last  <= (CCW'(w_cc) == w_ec - CCW'(1))
                                  && (r_crow == w_er - ROW_W'(1));
                        r_state   <= S_ADV;
                    end
                end
                S_ADV: begin
                    if (w_wrap) begin
                        r_pc        <= '0;
                        r_ccol      <= '0;
                        r_col_edge  <= r_first_col;
                        r_col_start <= '0;
                        if ({1'b0, w_pr1} >= {1'b0, w_eh}) begin
                            r_pr        <= '0;
                            r_crow      <= '0;
                            r_row_edge  <= r_first_row;
                            r_row_start <= '0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_pr <= w_pr1;
                            if (w_row_hit) begin
                                r_crow      <= r_crow + ROW_W'(1);
                                r_row_start <= r_row_edge;
                                r_div_a     <= SUM_W'((VW'(r_crow) + VW'(2)) * VW'(w_eh));
                                r_div_b     <= VW'(w_er);
                                r_state     <= S_DIV_ROW;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else begin
                        r_pc <= w_pc1;
                        if (w_col_hit) begin
                            r_ccol      <= r_ccol + CCW'(1);
                            r_col_start <= r_col_edge;
                            r_div_a     <= SUM_W'((VW'(r_ccol) + VW'(2)) * VW'(w_ew));
                            r_div_b     <= VW'(w_ec);
                            r_state     <= S_DIV_COL;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV_COL: begin
                    if (w_div_done) begin
                        r_col_edge <= PW'(w_div_q);
                        r_state    <= S_IDLE;
                    end
                end
                S_DIV_ROW: begin
                    if (w_div_done) begin
                        r_row_edge <= PW'(w_div_q);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

`ifndef ASSERT_OFF
    // position stays inside the frame between pixels
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_pc < w_ew) && (r_pr < w_eh)))
        else $error("pixel position outside frame");

    // current column and row cells stay below the cell counts between pixels
    a_cell_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_ccol < w_ec) && (r_crow < w_er)))
        else $error("cell index out of range");

    // divider finishes only while a division is awaited
    a_div_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_INIT_COL || r_state == S_INIT_ROW ||
                        r_state == S_DIV_MEAN || r_state == S_DIV_COL ||
                        r_state == S_DIV_ROW))
        else $error("unexpected divider completion");

    // a pending result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_m_tready) |=> r_o_valid && $stable(r_o_data))
        else $error("result overwritten");
`endif

endmodule

// ----- design/clsq_div.sv -----
module clsq_div #(
    parameter int DW = 40,
    parameter int VW = 26
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    import clsq_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [VW:0]   r_rem;
    logic [VW-1:0] r_den;
    logic [VW:0]   n_shift;
    logic          n_fit;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        n_shift = {r_rem[VW-1:0], r_q[DW-1]};
        n_fit   = n_shift >= {1'b0, r_den};
    end

    // One quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_fit ? (n_shift - {1'b0, r_den}) : n_shift;
                r_q   <= {r_q[DW-2:0], n_fit};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ----- sim/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clsq_pkg::*;

    typedef struct packed {
        logic [2:0]  shade;
        logic [15:0] mean;
        logic [7:0]  col;
        logic [7:0]  row;
        logic        last;
    } t_cell_result;

    typedef struct {
        logic [7:0]   red;
        logic [7:0]   green;
        logic [7:0]   blue;
        bit           known;
        t_cell_result result;
    } t_pixel_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cell_luminance_shade_quantizer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Luminance tables and shadow geometry
    logic [15:0]     lum_red [256];
    logic [15:0]     lum_green [256];
    logic [15:0]     lum_blue [256];
    int unsigned     geo_width, geo_height, geo_cols, geo_rows, geo_gain;
    longint unsigned cell_sum [256];
    int unsigned     pos_x, pos_y, cell_x, cell_y, edge_x, edge_y;

    t_cell_result pending_cells [$];
    int           error_count;
    int           src_idle_pct;
    int           dst_stall_pct;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Fifth power in Q30, truncating each product
    function automatic longint unsigned fifth_power(longint unsigned r);
        longint unsigned p;
        p = r;
        for (int k = 0; k < 4; k++) p = (p * r) >> 30;
        return p;
    endfunction

    // sRGB code to linear light in Q30
    function automatic longint unsigned srgb_to_linear(int unsigned v);
        longint unsigned one, t, s, lo, hi, mid;
        one = 64'd1 << 30;
        if (v <= 10) return (longint'(v) * 100 * one) / 329460;
        t  = ((longint'(v) * 1000 + 14025) * one) / 269025;
        s  = (t * t) >> 30;
        lo = 0;
        hi = one;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (fifth_power(mid) <= s) lo = mid;
            else hi = mid - 1;
        end
        return (s * lo) >> 30;
    endfunction

    function automatic int unsigned clamp_to(int unsigned x, int unsigned lo, int unsigned hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic int unsigned span_w();
        return clamp_to(geo_width, 1, 4096);
    endfunction
    function automatic int unsigned span_h();
        return clamp_to(geo_height, 1, 4096);
    endfunction
    function automatic int unsigned cells_x();
        return clamp_to(geo_cols, 1, span_w() < 256 ? span_w() : 256);
    endfunction
    function automatic int unsigned cells_y();
        return clamp_to(geo_rows, 1, span_h() < 256 ? span_h() : 256);
    endfunction

    function automatic int unsigned cell_edge(int unsigned i, int unsigned size,
                                              int unsigned cells);
        return int'((longint'(i) * size) / cells);
    endfunction

    // Return to the first pixel with empty sums
    function automatic void restart_frame();
        foreach (cell_sum[k]) cell_sum[k] = 0;
        pos_x  = 0;
        pos_y  = 0;
        cell_x = 0;
        cell_y = 0;
        edge_x = cell_edge(1, span_w(), cells_x());
        edge_y = cell_edge(1, span_h(), cells_y());
    endfunction

    function automatic void shadow_write(t_cfg_reg idx, logic [12:0] val);
        case (idx)
            REG_IMAGE_WIDTH:   begin geo_width  = val;       restart_frame(); end
            REG_IMAGE_HEIGHT:  begin geo_height = val;       restart_frame(); end
            REG_CELL_COLUMNS:  begin geo_cols   = val[8:0];  restart_frame(); end
            REG_CELL_ROWS:     begin geo_rows   = val[8:0];  restart_frame(); end
            REG_EXPOSURE_GAIN: geo_gain = val[11:0];
            default: ;
        endcase
    endfunction

    // Accumulate one pixel; queue the cell result when it closes a cell
    function automatic void accumulate_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned     w, h, c, rr, cc;
        longint unsigned area, mean, scaled;
        t_cell_result    res;
        w  = span_w();
        h  = span_h();
        c  = cells_x();
        rr = cells_y();
        cc = cell_x < 256 ? cell_x : 255;
        cell_sum[cc] = (cell_sum[cc] + lum_red[r] + lum_green[g] + lum_blue[b])
                       & ((64'd1 << 40) - 1);
        if (pos_x + 1 == edge_x && pos_y + 1 == edge_y) begin
            area = longint'(edge_x - cell_edge(cc, w, c)) *
                   longint'(edge_y - cell_edge(cell_y, h, rr));
            if (area == 0) area = 1;
            mean = cell_sum[cc] / area;
            if (mean > 65535) mean = 65535;
            scaled = mean * geo_gain;
            if (scaled > (64'd1 << 24)) scaled = 64'd1 << 24;
            res.shade = 3'((scaled * 4) >> 24);
            res.mean  = 16'(mean);
            res.col   = 8'(cc);
            res.row   = 8'(cell_y);
            res.last  = (cc == c - 1 && cell_y == rr - 1);
            pending_cells.push_back(res);
            cell_sum[cc] = 0;
        end
        if (pos_x + 1 == edge_x) begin
            cell_x++;
            edge_x = cell_edge(cell_x + 1, w, c);
        end
        pos_x++;
        if (pos_x >= w) begin
            pos_x  = 0;
            cell_x = 0;
            edge_x = cell_edge(1, w, c);
            pos_y++;
            if (pos_y == edge_y) begin
                cell_y++;
                edge_y = cell_edge(cell_y + 1, h, rr);
            end
            if (pos_y >= h) begin
                pos_y  = 0;
                cell_y = 0;
                edge_y = cell_edge(1, h, rr);
            end
        end
    endfunction

    // Receiver: random stall
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= dst_stall_pct);
    end

    // Check each result transaction against the oldest expected cell
    always @(posedge i_clk) begin
        t_cell_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[2:0], o_m_tdata[18:3], o_m_tdata[26:19],
                   o_m_tdata[34:27], o_m_tlast};
            if (pending_cells.size() == 0) begin
                error_count++;
                $display("%t: unexpected cell result %h", $time, got);
            end else begin
                want = pending_cells.pop_front();
                if (got != want || o_m_tdata[39:35] != 0) begin
                    error_count++;
                    $display("%t: expected shade %0d mean %0d col %0d row %0d last %0b",
                             $time, want.shade, want.mean, want.col, want.row, want.last);
                    $display("%t:   actual shade %0d mean %0d col %0d row %0d last %0b pad %h",
                             $time, got.shade, got.mean, got.col, got.row, got.last,
                             o_m_tdata[39:35]);
                end
            end
        end
    end

    // Hold the write until accepted; the caller drops valid after the last one
    task automatic write_reg(t_cfg_reg idx, logic [12:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_write(idx, val);
    endtask

    // Drain outstanding cells, let the block settle, then load all registers
    task automatic load_geometry(int unsigned w, int unsigned h, int unsigned c,
                                 int unsigned r, int unsigned g);
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        write_reg(REG_IMAGE_WIDTH, 13'(w));
        write_reg(REG_IMAGE_HEIGHT, 13'(h));
        write_reg(REG_CELL_COLUMNS, 13'(c));
        write_reg(REG_CELL_ROWS, 13'(r));
        write_reg(REG_EXPOSURE_GAIN, 13'(g));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {b, g, r};
        do @(posedge i_clk); while (!o_s_tready);
        accumulate_pixel(r, g, b);
    endtask

    function automatic logic [7:0] random_sample();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(12));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void pick_idling(int unsigned mode);
        case (mode % 4)
            0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
            1: begin src_idle_pct = 81; dst_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  dst_stall_pct = 81; end
            default: begin src_idle_pct = 33; dst_stall_pct = 33; end
        endcase
    endfunction

    initial begin
        t_pixel_row  dir_rows [$];
        t_pixel_row  row;
        int unsigned w, h, c, r, g, n, sent;
        int unsigned ext_w [6] = '{4096, 1,    0, 8191, 5,  9};
        int unsigned ext_h [6] = '{1,    4096, 0, 2,    3,  8191};
        int unsigned ext_c [6] = '{256,  1,    0, 511,  0,  300};
        int unsigned ext_r [6] = '{1,    256,  0, 0,    3,  511};
        int unsigned ext_g [6] = '{4095, 1,    0, 4095, 1,  256};
        int unsigned ext_n [6] = '{128,  128,  6, 40,   30, 60};

        foreach (lum_red[v]) begin
            longint unsigned lin;
            lin          = srgb_to_linear(v);
            lum_red[v]   = 16'((lin * 2126 * 65536) / (64'd10000 << 30));
            lum_green[v] = 16'((lin * 7152 * 65536) / (64'd10000 << 30));
            lum_blue[v]  = 16'((lin * 722 * 65536) / (64'd10000 << 30));
        end
        error_count   = 0;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        geo_width     = RST_IMAGE_WIDTH;
        geo_height    = RST_IMAGE_HEIGHT;
        geo_cols      = RST_CELL_COLUMNS;
        geo_rows      = RST_CELL_ROWS;
        geo_gain      = RST_EXPOSURE_GAIN;
        restart_frame();

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_IMAGE_WIDTH;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-pixel cells, channel extremes and the linear-segment split
        dir_rows = '{
            '{8'd0,   8'd0,   8'd0,   1'b1, '{3'd0, 16'd0, 8'd0, 8'd0, 1'b1}},
            '{8'd255, 8'd255, 8'd255, 1'b0, '0},
            '{8'd255, 8'd0,   8'd0,   1'b0, '0},
            '{8'd0,   8'd255, 8'd0,   1'b0, '0},
            '{8'd0,   8'd0,   8'd255, 1'b0, '0},
            '{8'd10,  8'd10,  8'd10,  1'b0, '0},
            '{8'd11,  8'd11,  8'd11,  1'b0, '0},
            '{8'd1,   8'd1,   8'd1,   1'b0, '0},
            '{8'd128, 8'd64,  8'd32,  1'b0, '0},
            '{8'd170, 8'd85,  8'd240, 1'b0, '0},
            '{8'd15,  8'd127, 8'd254, 1'b0, '0},
            '{8'd0,   8'd0,   8'd0,   1'b1, '{3'd0, 16'd0, 8'd0, 8'd0, 1'b1}}
        };
        load_geometry(1, 1, 1, 1, 768);
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            send_pixel(row.red, row.green, row.blue);
            // zero light is known without prediction
            if (row.known && pending_cells[$] != row.result) begin
                error_count++;
                $display("%t: directed row %0d expected %h predicted %h",
                         $time, k, row.result, pending_cells[$]);
            end
        end
        i_s_tvalid <= 1'b0;
        // Zero gain then maximum gain on white
        load_geometry(1, 1, 1, 1, 0);
        send_pixel(8'd255, 8'd255, 8'd255);
        i_s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        write_reg(REG_EXPOSURE_GAIN, 13'd4095);
        i_cfg_valid <= 1'b0;
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd40, 8'd40, 8'd40);

        // Extreme and out-of-range geometry
        foreach (ext_w[k]) begin
            i_s_tvalid <= 1'b0;
            pick_idling(k < 2 ? 0 : k);
            load_geometry(ext_w[k], ext_h[k], ext_c[k], ext_r[k], ext_g[k]);
            for (int p = 0; p < ext_n[k]; p++)
                send_pixel(random_sample(), random_sample(), random_sample());
        end

        // Random geometry with one or two frames of random pixels, at most 150 per geometry
        sent = 0;
        for (int ph = 0; sent < 500; ph++) begin
            i_s_tvalid <= 1'b0;
            pick_idling(ph);
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 16);
            c = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, w);
            r = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, h);
            case ($urandom_range(5))
                0: g = 0;
                1: g = 4095;
                default: g = $urandom_range(1, 4095);
            endcase
            load_geometry(w, h, c, r, g);
            n = w * h * $urandom_range(1, 2);
            if (n > 150) n = 150;
            for (int p = 0; p < n; p++)
                send_pixel(random_sample(), random_sample(), random_sample());
            sent += n;
        end
        i_s_tvalid <= 1'b0;

        // Drain and settle
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
